@@ sv/assert_macros.svh @@
// Assertion helpers used by the checker file qmci_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication with a fixed delay
`define ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error("assertion failed");

`endif

@@ sv/qmci_pkg.sv @@
package qmci_pkg;

    localparam int COORD_W   = 24;
    localparam int RADIUS_W  = 23;
    localparam int SIZE_W    = 16;
    localparam int OFS_W     = 27;
    localparam int QUOT_W    = 17;
    localparam int LANES     = 4;
    localparam int INDEX_W   = 32;
    localparam int SHIFT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int LATENCY   = QUOT_W + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic [RADIUS_W-1:0]       radius;
    } qmci_in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] cell_index;
        logic [SHIFT_W-1:0] shift_pairs;
        logic               out_of_range;
    } qmci_out_t;

    // one divider lane: dividend shifts out, quotient shifts in
    typedef struct packed {
        logic [QUOT_W-1:0] num;
        logic [SIZE_W-1:0] rem;
        logic              neg;
    } qmci_lane_t;

    typedef qmci_lane_t [LANES-1:0] qmci_lanes_t;

endpackage

@@ sv/quadtree_morton_cell_index.sv @@
// An accepted item passes the input register, the divider cells, the mid register and the result register before done.
// Throughput: one item per cycle; busy stays low, start may be high every cycle.
// The 17-cell restoring divider chain (one quotient bit per cell) sets the latency.
// Reset clears all valid bits and sets origin 0 and cell size 1.
// The receiver cannot stall: each result shows on result for one cycle with done.
module quadtree_morton_cell_index #(
    parameter int AXIS_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  qmci_pkg::qmci_in_t             item,
    output logic                           done,
    output qmci_pkg::qmci_out_t            result,
    input  logic                           cfg_we,
    input  logic [qmci_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [qmci_pkg::COORD_W-1:0]   cfg_wdata
);

    localparam int MW = 2 * AXIS_BITS;

    logic signed [qmci_pkg::COORD_W-1:0] origin_x_reg;
    logic signed [qmci_pkg::COORD_W-1:0] origin_y_reg;
    logic [qmci_pkg::SIZE_W-1:0]         cell_width_reg;
    logic [qmci_pkg::SIZE_W-1:0]         cell_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            cell_width_reg  <= qmci_pkg::SIZE_W'(1);
            cell_height_reg <= qmci_pkg::SIZE_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qmci_pkg::CFG_ORIGIN_X:    origin_x_reg    <= cfg_wdata;
                qmci_pkg::CFG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata;
                qmci_pkg::CFG_CELL_WIDTH:  cell_width_reg  <= cfg_wdata[qmci_pkg::SIZE_W-1:0];
                qmci_pkg::CFG_CELL_HEIGHT: cell_height_reg <= cfg_wdata[qmci_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [qmci_pkg::SIZE_W-1:0] div_x;
    logic [qmci_pkg::SIZE_W-1:0] div_y;
    assign div_x = (cell_width_reg == '0) ? qmci_pkg::SIZE_W'(1) : cell_width_reg;
    assign div_y = (cell_height_reg == '0) ? qmci_pkg::SIZE_W'(1) : cell_height_reg;

    assign busy = 1'b0;

    // corner offsets
    logic signed [qmci_pkg::OFS_W-1:0] cx, cy, rr, ox, oy;
    logic signed [qmci_pkg::OFS_W-1:0] ofs [qmci_pkg::LANES];
    qmci_pkg::qmci_lanes_t             s0_lanes_next;

    always_comb
    begin
        cx = qmci_pkg::OFS_W'(item.center_x);
        cy = qmci_pkg::OFS_W'(item.center_y);
        rr = $signed({4'b0, item.radius});
        ox = qmci_pkg::OFS_W'(origin_x_reg);
        oy = qmci_pkg::OFS_W'(origin_y_reg);
        ofs[0] = cx - rr - ox;
        ofs[1] = cx + rr - ox;
        ofs[2] = cy - rr - oy;
        ofs[3] = cy + rr - oy;
        for (int k = 0; k < qmci_pkg::LANES; k++)
        begin
            s0_lanes_next[k].neg = ofs[k][qmci_pkg::OFS_W-1];
            s0_lanes_next[k].num = ofs[k][qmci_pkg::QUOT_W+7:8];
            s0_lanes_next[k].rem = '0;
        end
    end

    logic                  s0_valid_reg;
    qmci_pkg::qmci_lanes_t s0_lanes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_lanes_reg <= s0_lanes_next;
    end

    logic                  chain_valid [qmci_pkg::QUOT_W+1];
    qmci_pkg::qmci_lanes_t chain_lanes [qmci_pkg::QUOT_W+1];

    assign chain_valid[0] = s0_valid_reg;
    assign chain_lanes[0] = s0_lanes_reg;

    for (genvar g = 0; g < qmci_pkg::QUOT_W; g++)
    begin : g_cell
        qmci_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid     (chain_valid[g]),
            .lanes     (chain_lanes[g]),
            .div_x     (div_x),
            .div_y     (div_y),
            .valid_out (chain_valid[g+1]),
            .lanes_out (chain_lanes[g+1])
        );
    end

    // saturate and interleave
    qmci_pkg::qmci_lanes_t q;
    logic [AXIS_BITS-1:0]  cell_c [qmci_pkg::LANES];
    logic [qmci_pkg::LANES-1:0] sat;
    logic [MW-1:0]         code_lo, code_hi;

    always_comb
    begin
        q = chain_lanes[qmci_pkg::QUOT_W];
        for (int k = 0; k < qmci_pkg::LANES; k++)
        begin
            if (q[k].neg)
            begin
                cell_c[k] = '0;
                sat[k]    = 1'b1;
            end
            else if (|q[k].num[qmci_pkg::QUOT_W-1:AXIS_BITS])
            begin
                cell_c[k] = '1;
                sat[k]    = 1'b1;
            end
            else
            begin
                cell_c[k] = q[k].num[AXIS_BITS-1:0];
                sat[k]    = 1'b0;
            end
        end
        for (int i = 0; i < AXIS_BITS; i++)
        begin
            code_lo[2*i]   = cell_c[0][i];
            code_lo[2*i+1] = cell_c[2][i];
            code_hi[2*i]   = cell_c[1][i];
            code_hi[2*i+1] = cell_c[3][i];
        end
    end

    logic          mid_valid_reg;
    logic [MW-1:0] code_lo_reg;
    logic [MW-1:0] diff_reg;
    logic          flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= chain_valid[qmci_pkg::QUOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        code_lo_reg <= code_lo;
        diff_reg    <= code_lo ^ code_hi;
        flag_reg    <= |sat;
    end

    // level = highest differing pair plus one
    logic [qmci_pkg::SHIFT_W-1:0] level;
    logic [qmci_pkg::INDEX_W-1:0] code_ext;
    qmci_pkg::qmci_out_t          result_next;

    always_comb
    begin
        level = '0;
        for (int i = 0; i < AXIS_BITS; i++)
        begin
            if (diff_reg[2*i +: 2] != 2'b00)
            begin
                level = qmci_pkg::SHIFT_W'(i + 1);
            end
        end
        code_ext                 = qmci_pkg::INDEX_W'(code_lo_reg);
        result_next.cell_index   = code_ext >> {level, 1'b0};
        result_next.shift_pairs  = level;
        result_next.out_of_range = flag_reg;
    end

    logic                done_reg;
    qmci_pkg::qmci_out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ sv/qmci_cell.sv @@
module qmci_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    input  qmci_pkg::qmci_lanes_t       lanes,
    input  logic [qmci_pkg::SIZE_W-1:0] div_x,
    input  logic [qmci_pkg::SIZE_W-1:0] div_y,
    output logic                        valid_out,
    output qmci_pkg::qmci_lanes_t       lanes_out
);

    logic                  valid_reg;
    qmci_pkg::qmci_lanes_t lanes_reg;
    qmci_pkg::qmci_lanes_t lanes_next;

    // one restoring step per lane; lanes 0,1 are x, lanes 2,3 are y
    always_comb
    begin
        for (int k = 0; k < qmci_pkg::LANES; k++)
        begin
            logic [qmci_pkg::SIZE_W:0] t;
            logic [qmci_pkg::SIZE_W:0] d;
            logic                      ge;
            logic [qmci_pkg::SIZE_W:0] diff;
            t    = {lanes[k].rem, lanes[k].num[qmci_pkg::QUOT_W-1]};
            d    = {1'b0, (k < 2) ? div_x : div_y};
            ge   = (t >= d);
            diff = t - d;
            lanes_next[k].neg = lanes[k].neg;
            lanes_next[k].num = {lanes[k].num[qmci_pkg::QUOT_W-2:0], ge};
            lanes_next[k].rem = ge ? diff[qmci_pkg::SIZE_W-1:0] : t[qmci_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lanes_reg <= lanes_next;
    end

    assign valid_out = valid_reg;
    assign lanes_out = lanes_reg;

endmodule

@@ sv/qmci_checker.sv @@
`include "assert_macros.svh"

module qmci_checker #(
    parameter int AXIS_BITS = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input qmci_pkg::qmci_out_t result
);

    `ASSERT_DLY(a_latency, clk, rst_n, start && !busy, qmci_pkg::LATENCY, done)
    `ASSERT_IMP(a_no_spurious, clk, rst_n, done, $past(start && !busy, qmci_pkg::LATENCY))
    `ASSERT_IMP(a_shift_range, clk, rst_n, done, result.shift_pairs <= AXIS_BITS)
    `ASSERT_IMP(a_whole_grid, clk, rst_n, done && (result.shift_pairs == AXIS_BITS), result.cell_index == '0)

endmodule

bind quadtree_morton_cell_index qmci_checker #(.AXIS_BITS(AXIS_BITS)) u_qmci_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
